[hw/rtl/utf8d_pkg.sv]
// Shared types and constants for the UTF-8 code point decoder.
// Holds the byte window and result structs, the lead byte masks and the length codes.
// No dependencies.
package utf8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned AVAIL_W  = 3;
    localparam int unsigned CP_W     = 31;
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 40;

    // Lead byte class masks and patterns.
    localparam logic [7:0] MASK_CONT  = 8'b1100_0000;
    localparam logic [7:0] PAT_CONT   = 8'b1000_0000;
    localparam logic [7:0] MASK_LEN6  = 8'b1111_1110;
    localparam logic [7:0] PAT_LEN6   = 8'b1111_1100;
    localparam logic [7:0] MASK_LEN5  = 8'b1111_1100;
    localparam logic [7:0] PAT_LEN5   = 8'b1111_1000;
    localparam logic [7:0] MASK_LEN4  = 8'b1111_1000;
    localparam logic [7:0] PAT_LEN4   = 8'b1111_0000;
    localparam logic [7:0] MASK_LEN3  = 8'b1111_0000;
    localparam logic [7:0] PAT_LEN3   = 8'b1110_0000;
    localparam logic [7:0] MASK_LEN2  = 8'b1110_0000;
    localparam logic [7:0] PAT_LEN2   = 8'b1100_0000;
    localparam logic [5:0] MASK_PAYLD = 6'b11_1111;

    // Encoded length codes.
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1    = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2    = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3    = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4    = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5    = 3'd5;
    localparam logic [LEN_W-1:0] LEN_6    = 3'd6;

    typedef struct packed {
        logic [AVAIL_W-1:0] bytes_available;
        logic [BYTE_W-1:0]  next_byte_5;
        logic [BYTE_W-1:0]  next_byte_4;
        logic [BYTE_W-1:0]  next_byte_3;
        logic [BYTE_W-1:0]  next_byte_2;
        logic [BYTE_W-1:0]  next_byte_1;
        logic [BYTE_W-1:0]  lead_byte;
    } t_window;

    typedef struct packed {
        logic [LEN_W-1:0] encoded_length;
        logic [CP_W-1:0]  code_point;
    } t_result;

endpackage

[hw/rtl/utf8d_decode.sv]
// Combinational decode of one registered byte window into a code point and length.
// Depends on utf8d_pkg.
module utf8d_decode
    import utf8d_pkg::*;
(
    input  t_window i_window,
    output t_result o_result
);

    logic [7:0]       w_c;
    logic [5:0]       w_p1;
    logic [5:0]       w_p2;
    logic [5:0]       w_p3;
    logic [5:0]       w_p4;
    logic [5:0]       w_p5;
    logic             w_cont;
    logic [LEN_W-1:0] w_len;
    logic             w_complete;
    logic [CP_W-1:0]  w_cp;

    assign w_c    = i_window.lead_byte;
    assign w_p1   = i_window.next_byte_1[5:0] & MASK_PAYLD;
    assign w_p2   = i_window.next_byte_2[5:0] & MASK_PAYLD;
    assign w_p3   = i_window.next_byte_3[5:0] & MASK_PAYLD;
    assign w_p4   = i_window.next_byte_4[5:0] & MASK_PAYLD;
    assign w_p5   = i_window.next_byte_5[5:0] & MASK_PAYLD;
    assign w_cont = (w_c & MASK_CONT) == PAT_CONT;

    always_comb begin
        priority if (w_cont) begin
            w_len = LEN_1;
        end else if ((w_c & MASK_LEN6) == PAT_LEN6) begin
            w_len = LEN_6;
        end else if ((w_c & MASK_LEN5) == PAT_LEN5) begin
            w_len = LEN_5;
        end else if ((w_c & MASK_LEN4) == PAT_LEN4) begin
            w_len = LEN_4;
        end else if ((w_c & MASK_LEN3) == PAT_LEN3) begin
            w_len = LEN_3;
        end else if ((w_c & MASK_LEN2) == PAT_LEN2) begin
            w_len = LEN_2;
        end else begin
            w_len = LEN_1;
        end
    end

    // An availability of seven counts as six or more, so a plain compare works.
    assign w_complete = i_window.bytes_available >= w_len;

    always_comb begin
        w_cp = {{(CP_W-BYTE_W){1'b0}}, w_c};
        if (w_cont) begin
            w_cp = '0;
        end else if (w_complete) begin
            unique case (w_len)
                LEN_2:   w_cp = {20'd0, w_c[4:0], w_p1};
                LEN_3:   w_cp = {15'd0, w_c[3:0], w_p1, w_p2};
                LEN_4:   w_cp = {10'd0, w_c[2:0], w_p1, w_p2, w_p3};
                LEN_5:   w_cp = {5'd0, w_c[1:0], w_p1, w_p2, w_p3, w_p4};
                LEN_6:   w_cp = {w_c[0], w_p1, w_p2, w_p3, w_p4, w_p5};
                default: w_cp = {{(CP_W-BYTE_W){1'b0}}, w_c};
            endcase
        end
    end

    always_comb begin
        if (i_window.bytes_available == '0) begin
            o_result.code_point     = '0;
            o_result.encoded_length = LEN_NONE;
        end else begin
            o_result.code_point     = w_cp;
            o_result.encoded_length = w_len;
        end
    end

endmodule

[hw/rtl/utf8_code_point_decoder_unit.sv]
// Top level of the UTF-8 code point decoder: input register, decode, result register.
// Depends on utf8d_pkg and utf8d_decode.
//
// Usage:
// The slave channel takes one byte window per transaction: the lead byte, the five
// bytes after it and the count of bytes still available (seven means six or more). The
// master channel returns one transaction per window with the decoded code point
// and the sequence length announced by the lead byte.
// The window is captured in the input register at the accepting edge, then moves into the
// result register, which offers it on the master side until it is taken.
// Throughput is one window per cycle while i_m_tready keeps up; the decode is a single
// short pass of mask, compare and concatenation logic between the two registers.
// Both registers advance together whenever the result register is empty or its
// transaction completes, so a stalled receiver holds the result and the input
// register, and o_s_tready drops only once both are occupied.
// A synchronous active-low reset empties both registers; no result is pending
// afterward and the block is ready at the next edge.
module utf8_code_point_decoder_unit
    import utf8d_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // Fields from bit 0: lead_byte[7:0], next_byte_1..5 (8 bits each),
    // bytes_available[50:48], zero pad.
    input  logic [S_DATA_W-1:0] i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // Fields from bit 0: code_point[30:0], encoded_length[33:31], zero pad.
    output logic [M_DATA_W-1:0] o_m_tdata
);

    logic    r_in_valid;
    logic    n_in_valid;
    t_window r_window;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_result;
    t_result w_result;
    logic    w_adv;

    // Pipeline moves when the result register can take a new value.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;

    assign n_in_valid  = o_s_tready ? i_s_tvalid : r_in_valid;
    assign n_out_valid = w_adv ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_window <= t_window'(i_s_tdata[$bits(t_window)-1:0]);
        end
        if (w_adv && r_in_valid) begin
            r_result <= w_result;
        end
    end

    utf8d_decode u_decode (
        .i_window (r_window),
        .o_result (w_result)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-$bits(t_result)){1'b0}}, r_result};

`ifndef SYNTHESIS
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.encoded_length <= LEN_6))
        else $error("encoded length above six");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.encoded_length == LEN_NONE)
            |-> (r_result.code_point == '0))
        else $error("empty window gave a nonzero code point");

    a_len1_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.encoded_length == LEN_1)
            |-> (r_result.code_point[CP_W-1:8] == '0))
        else $error("single-byte result wider than a byte");

    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv) |=> r_out_valid)
        else $error("window left the input register without a result");

    a_in_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_window)))
        else $error("held window lost while the result stalled");
`endif

endmodule

[tb/sv/utf8_code_point_decoder_unit_tb.sv]
// Self-checking testbench for utf8_code_point_decoder_unit: directed table, then random windows.
// Each result is checked against a typed expectation or a decoder modeled here; depends on utf8d_pkg and the RTL.
`timescale 1ns / 1ps

module utf8_code_point_decoder_unit_tb;
    import utf8d_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1930;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct {
        t_window win;
        bit      typed;
        t_result want;
    } t_vector;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    // Fields from bit 0: lead_byte, next_byte_1..5, bytes_available, zero pad.
    logic [S_DATA_W-1:0] i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    // Fields from bit 0: code_point, encoded_length, zero pad.
    logic [M_DATA_W-1:0] o_m_tdata;

    t_result     pending_results[$];
    t_result     offered_result;
    t_vector     plan[$];
    int unsigned mismatch_count;
    int unsigned results_seen;
    int unsigned cycle_count;
    bit          steady;

    utf8_code_point_decoder_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Lead byte class decides the length; the payload is only assembled when the
    // whole sequence is inside the window.
    function automatic t_result decode_window(input t_window w);
        t_result          r;
        logic [4:0][7:0]  tail;
        logic [2:0]       n;
        logic [30:0]      cp;
        logic [7:0]       lb;
        lb   = w.lead_byte;
        tail = {w.next_byte_5, w.next_byte_4, w.next_byte_3, w.next_byte_2, w.next_byte_1};
        if (w.bytes_available == 3'd0) begin
            r.code_point     = '0;
            r.encoded_length = LEN_NONE;
            return r;
        end
        if ((lb & MASK_CONT) == PAT_CONT)      n = LEN_1;
        else if ((lb & MASK_LEN6) == PAT_LEN6) n = LEN_6;
        else if ((lb & MASK_LEN5) == PAT_LEN5) n = LEN_5;
        else if ((lb & MASK_LEN4) == PAT_LEN4) n = LEN_4;
        else if ((lb & MASK_LEN3) == PAT_LEN3) n = LEN_3;
        else if ((lb & MASK_LEN2) == PAT_LEN2) n = LEN_2;
        else                                   n = LEN_1;
        if ((lb & MASK_CONT) == PAT_CONT) begin
            cp = '0;
        end else if (n >= LEN_2 && w.bytes_available >= n) begin
            cp = 31'(lb & ((8'd1 << (3'd7 - n)) - 8'd1));
            for (int i = 1; i < int'(n); i++)
                cp = {cp[24:0], tail[i-1][5:0] & MASK_PAYLD};
        end else begin
            cp = 31'(lb);
        end
        r.code_point     = cp;
        r.encoded_length = n;
        return r;
    endfunction

    function automatic t_vector row(input logic [7:0] lb, input logic [7:0] n1,
                                    input logic [7:0] n2, input logic [7:0] n3,
                                    input logic [7:0] n4, input logic [7:0] n5,
                                    input logic [2:0] avail, input bit typed,
                                    input logic [30:0] cp, input logic [2:0] len);
        t_vector v;
        v.win.lead_byte       = lb;
        v.win.next_byte_1     = n1;
        v.win.next_byte_2     = n2;
        v.win.next_byte_3     = n3;
        v.win.next_byte_4     = n4;
        v.win.next_byte_5     = n5;
        v.win.bytes_available = avail;
        v.typed               = typed;
        v.want.code_point     = cp;
        v.want.encoded_length = len;
        return v;
    endfunction

    function automatic int unsigned idle_gap();
        if (steady || $urandom_range(99) >= 15) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Random byte forced into a lead or continuation class.
    function automatic logic [7:0] class_byte(input logic [7:0] mask, input logic [7:0] pat);
        return (8'($urandom) & ~mask) | pat;
    endfunction

    task automatic send_window(input t_window w, input t_result want);
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        offered_result = want;
        i_s_tvalid    <= 1'b1;
        i_s_tdata     <= S_DATA_W'(w);
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    // Both handshakes are observed at the rising edge, after the inputs settled at
    // the falling edge.
    always @(posedge i_clk) begin : observe
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                pending_results.push_back(offered_result);
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                got = t_result'(o_m_tdata[CP_W+LEN_W-1:0]);
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected transaction", 0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.code_point != want.code_point)
                        note_mismatch("code_point", want.code_point, got.code_point);
                    if (got.encoded_length != want.encoded_length)
                        note_mismatch("encoded_length", want.encoded_length,
                                      got.encoded_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver side. One long hold-off lets the block fill up and drop its ready.
    initial begin : receiver
        int unsigned hold;
        bit          held_once;
        hold      = 0;
        held_once = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_once && results_seen >= 400) begin
                held_once = 1'b1;
                hold      = 80;
            end
            if (hold != 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    initial begin : stimulus
        t_window     w;
        int unsigned len;
        mismatch_count = 0;
        results_seen   = 0;
        cycle_count    = 0;
        steady         = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        offered_result = '0;

        // No data, stray continuations, raw leads, extremes and truncation.
        plan.push_back(row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1, 31'h0, LEN_NONE));
        plan.push_back(row(8'hC3, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1, 31'h0, LEN_NONE));
        plan.push_back(row(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd1, 1, 31'h0, LEN_1));
        plan.push_back(row(8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1, 31'h7F, LEN_1));
        plan.push_back(row(8'h80, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6, 1, 31'h0, LEN_1));
        plan.push_back(row(8'hBF, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 3'd3, 1, 31'h0, LEN_1));
        plan.push_back(row(8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6, 1, 31'hFE, LEN_1));
        plan.push_back(row(8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd7, 1, 31'hFF, LEN_1));
        plan.push_back(row(8'hC2, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 0, 31'h0, LEN_NONE));
        plan.push_back(row(8'hC0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 1, 31'h0, LEN_2));
        plan.push_back(row(8'hDF, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 1, 31'h7FF, LEN_2));
        plan.push_back(row(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd3, 0, 31'h0, LEN_NONE));
        plan.push_back(row(8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00, 8'h00, 3'd2, 1, 31'hE2, LEN_3));
        plan.push_back(row(8'hEF, 8'hBF, 8'hBF, 8'h00, 8'h00, 8'h00, 3'd7, 1, 31'hFFFF, LEN_3));
        plan.push_back(row(8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00, 8'h00, 3'd4, 0, 31'h0, LEN_NONE));
        plan.push_back(row(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'h00, 3'd3, 1, 31'hF7, LEN_4));
        plan.push_back(row(8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h00, 3'd5, 0, 31'h0, LEN_NONE));
        plan.push_back(row(8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00, 3'd6, 1, 31'h3FFFFFF,
                           LEN_5));
        plan.push_back(row(8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 3'd6, 0, 31'h0, LEN_NONE));
        plan.push_back(row(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd6, 1, 31'h7FFFFFFF,
                           LEN_6));
        plan.push_back(row(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd5, 1, 31'hFD, LEN_6));
        plan.push_back(row(8'hFC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 1, 31'h0, LEN_6));
        plan.push_back(row(8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd6, 1, 31'h41, LEN_1));
        plan.push_back(row(8'hC3, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 0, 31'h0, LEN_NONE));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k])
            send_window(plan[k].win, plan[k].typed ? plan[k].want : decode_window(plan[k].win));

        for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
            steady = (k >= 1000 && k < 1300);
            w = $bits(t_window)'({$urandom, $urandom});
            if ($urandom_range(99) < 75) begin
                // Well-formed sequence with random payload; the availability is
                // usually enough, sometimes short of the announced length.
                len = $urandom_range(1, 6);
                case (len)
                    1: w.lead_byte = {1'b0, 7'($urandom)};
                    2: w.lead_byte = class_byte(MASK_LEN2, PAT_LEN2);
                    3: w.lead_byte = class_byte(MASK_LEN3, PAT_LEN3);
                    4: w.lead_byte = class_byte(MASK_LEN4, PAT_LEN4);
                    5: w.lead_byte = class_byte(MASK_LEN5, PAT_LEN5);
                    default: w.lead_byte = class_byte(MASK_LEN6, PAT_LEN6);
                endcase
                if (len > 1) w.next_byte_1 = class_byte(MASK_CONT, PAT_CONT);
                if (len > 2) w.next_byte_2 = class_byte(MASK_CONT, PAT_CONT);
                if (len > 3) w.next_byte_3 = class_byte(MASK_CONT, PAT_CONT);
                if (len > 4) w.next_byte_4 = class_byte(MASK_CONT, PAT_CONT);
                if (len > 5) w.next_byte_5 = class_byte(MASK_CONT, PAT_CONT);
                if ($urandom_range(99) < 85)
                    w.bytes_available = 3'($urandom_range(len, 7));
                else
                    w.bytes_available = 3'($urandom_range(0, len - 1));
            end
            send_window(w, decode_window(w));
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
